// File: rtl/okle_pkg.sv
// shared types, codes and sizes for the ordered keyed list engine
package okle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] name_tag;
    logic [15:0] ride_tag;
  } entry_t;

  typedef enum logic [2:0] {
    REQ_INS_BACK  = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_REMOVE    = 3'd2,
    REQ_POP_FRONT = 3'd3,
    REQ_LOOKUP    = 3'd4,
    REQ_SUCC      = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_FRONT,
    CMD_DROP_HIT
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        occ;
    logic        at_tail;
    logic [15:0] key;
  } cell_ctl_t;

endpackage

// File: rtl/ordered_keyed_list_engine.sv
// top level of the ordered keyed list engine: request control and cell chain
// a request is captured in the request registers on acceptance and its result is then
//   registered in the result register, held back only by a stalled earlier result;
//   the input is stalled while the captured request executes against the cell row
// reset clears the entry count and the handshake state; slot contents are
//   not cleared and are only read below the count
module ordered_keyed_list_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                req_type,
  input  logic [15:0]               key_id,
  input  logic [15:0]               name_tag,
  input  logic [15:0]               ride_tag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [15:0]               hit_id,
  output logic [15:0]               hit_name_tag,
  output logic [15:0]               hit_ride_tag,
  output logic [4:0]                entry_count
);
  import okle_pkg::*;

  // fsm
  state_t state, state_next;

  // captured request
  req_t        req;
  entry_t      req_entry;

  // list occupancy
  logic [CNT_W-1:0] count, count_next;

  // cell chain
  entry_t           cell_entry [CAPACITY];
  cell_ctl_t        cell_ctl   [CAPACITY];
  logic [CAPACITY:0]   prior;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] last;
  logic [CAPACITY-1:0] succ_sel;

  // execute-cycle decisions
  logic    go;
  logic    full;
  logic    found;
  cmd_t    cmd;
  status_t st_calc;
  entry_t  hit_calc;
  entry_t  look_hit;
  entry_t  succ_hit;
  logic [CNT_W+4:0] cnt_wide;

  assign in_stall = (state != S_IDLE);
  assign prior[0] = 1'b0;

  // result register frees up when empty or being taken this cycle
  assign go    = (state == S_EXEC) && (!out_valid || !out_stall);
  assign full  = (count == CNT_W'(CAPACITY));
  assign found = |first;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t left_src;
      entry_t right_src;

      if (gi == 0) begin : g_head
        assign left_src = req_entry;
      end else begin : g_body
        assign left_src = cell_entry[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_src = cell_entry[gi];
      end else begin : g_mid
        assign right_src = cell_entry[gi+1];
      end

      assign last[gi]             = (count == CNT_W'(gi + 1));
      assign cell_ctl[gi].cmd     = cmd;
      assign cell_ctl[gi].occ     = (count > CNT_W'(gi));
      assign cell_ctl[gi].at_tail = (count == CNT_W'(gi));
      assign cell_ctl[gi].key     = req_entry.id;

      // successor: next cell after the first match, wrapping from the back
      if (gi == 0) begin : g_wrap
        assign succ_sel[gi] = |(first & last);
      end else begin : g_next
        assign succ_sel[gi] = first[gi-1] && !last[gi-1];
      end

      okle_cell u_cell (
        .clk         (clk),
        .ctl         (cell_ctl[gi]),
        .new_entry   (req_entry),
        .left_entry  (left_src),
        .right_entry (right_src),
        .prior_in    (prior[gi]),
        .entry       (cell_entry[gi]),
        .prior_out   (prior[gi+1]),
        .first_hit   (first[gi])
      );
    end
  endgenerate

  // pick the hit entries out of the row
  always_comb begin
    look_hit = '0;
    succ_hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      look_hit = look_hit | (first[i]    ? cell_entry[i] : '0);
      succ_hit = succ_hit | (succ_sel[i] ? cell_entry[i] : '0);
    end
  end

  // request decode
  always_comb begin
    cmd        = CMD_HOLD;
    st_calc    = ST_MISS;
    hit_calc   = '0;
    count_next = count;
    case (req)
      REQ_INS_BACK: begin
        if (full) begin
          st_calc = ST_FULL;
        end else begin
          cmd        = CMD_PUSH_BACK;
          st_calc    = ST_DONE;
          count_next = count + 1'b1;
        end
      end
      REQ_INS_FRONT: begin
        if (full) begin
          st_calc = ST_FULL;
        end else begin
          cmd        = CMD_PUSH_FRONT;
          st_calc    = ST_DONE;
          count_next = count + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          cmd        = CMD_DROP_HIT;
          st_calc    = ST_DONE;
          count_next = count - 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (count != '0) begin
          cmd        = CMD_POP_FRONT;
          st_calc    = ST_DONE;
          count_next = count - 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (found) begin
          st_calc  = ST_DONE;
          hit_calc = look_hit;
        end
      end
      REQ_SUCC: begin
        if (found) begin
          st_calc  = ST_DONE;
          hit_calc = succ_hit;
        end
      end
      default: begin
      end
    endcase
    // nothing moves unless the result is committed this cycle
    if (!go) begin
      cmd        = CMD_HOLD;
      count_next = count;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req                <= req_t'(req_type);
      req_entry.id       <= key_id;
      req_entry.name_tag <= name_tag;
      req_entry.ride_tag <= ride_tag;
    end
  end

  // result register, count reported in its low five bits
  assign cnt_wide = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (go) begin
      status       <= st_calc;
      hit_id       <= hit_calc.id;
      hit_name_tag <= hit_calc.name_tag;
      hit_ride_tag <= hit_calc.ride_tag;
      entry_count  <= cnt_wide[4:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_first_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one first match in the chain");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> full)
    else $error("full status while the list has room");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("count moved without a committed request");
`endif

endmodule

// File: rtl/okle_cell.sv
// one list slot: holds an entry, compares its id and shifts with its neighbors
module okle_cell (
  input  logic               clk,
  input  okle_pkg::cell_ctl_t ctl,
  input  okle_pkg::entry_t   new_entry,
  input  okle_pkg::entry_t   left_entry,
  input  okle_pkg::entry_t   right_entry,
  input  logic               prior_in,
  output okle_pkg::entry_t   entry,
  output logic               prior_out,
  output logic               first_hit
);
  import okle_pkg::*;

  logic match;

  assign match     = ctl.occ && (entry.id == ctl.key);
  assign first_hit = match && !prior_in;
  assign prior_out = prior_in || match;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_PUSH_BACK: begin
        if (ctl.at_tail) begin
          entry <= new_entry;
        end
      end
      CMD_PUSH_FRONT: begin
        entry <= left_entry;
      end
      CMD_POP_FRONT: begin
        entry <= right_entry;
      end
      CMD_DROP_HIT: begin
        // close the gap from the first match onward
        if (prior_in || match) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
